@@ sv/pscm_pkg.sv @@
`default_nettype none
package pscm_pkg;
  localparam int unsigned MaxSubs = 1024;
  localparam int unsigned MaxConstraints = 8;
  localparam int unsigned MaxPairs = 16;
  localparam int unsigned Attributes = 64;
  localparam int unsigned ValueBits = 32;

  typedef enum logic [1:0] {
    CMD_WRITE_CONSTRAINT = 2'd0,
    CMD_SET_COUNT        = 2'd1,
    CMD_EVENT_PAIR       = 2'd2,
    CMD_UNUSED           = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OP_EQ   = 2'd0,
    OP_GE   = 2'd1,
    OP_LE   = 2'd2,
    OP_RNG  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_WALK  = 3'd1,
    ST_DRAIN = 3'd2,
    ST_OUT   = 3'd3,
    ST_CLEAR = 3'd4
  } state_e;
endpackage
`default_nettype wire

@@ sv/pscm_eval.sv @@
`default_nettype none
// checks one constraint against all buffered pairs in parallel
module pscm_eval #(
  parameter int unsigned MAX_PAIRS  = pscm_pkg::MaxPairs,
  parameter int unsigned VALUE_BITS = pscm_pkg::ValueBits
) (
  input  wire logic [MAX_PAIRS-1:0]                 pair_valid_i,
  input  wire logic [MAX_PAIRS-1:0][5:0]            pair_attr_i,
  input  wire logic [MAX_PAIRS-1:0][VALUE_BITS-1:0] pair_val_i,
  input  wire logic [5:0]                           c_attr_i,
  input  wire logic [1:0]                           c_op_i,
  input  wire logic [VALUE_BITS-1:0]                c_lo_i,
  input  wire logic [VALUE_BITS-1:0]                c_hi_i,
  output      logic                                 hit_o
);
  logic [MAX_PAIRS-1:0] hits;
  always_comb begin
    for (int p = 0; p < MAX_PAIRS; p++) begin
      logic ok;
      ok = 1'b0;
      case (pscm_pkg::op_e'(c_op_i))
        pscm_pkg::OP_EQ:  ok = pair_val_i[p] == c_lo_i;
        pscm_pkg::OP_GE:  ok = pair_val_i[p] >= c_lo_i;
        pscm_pkg::OP_LE:  ok = pair_val_i[p] <= c_lo_i;
        pscm_pkg::OP_RNG: ok = (pair_val_i[p] >= c_lo_i) && (pair_val_i[p] <= c_hi_i);
        default:          ok = 1'b0;
      endcase
      hits[p] = pair_valid_i[p] && (pair_attr_i[p] == c_attr_i) && ok;
    end
  end
  assign hit_o = |hits;
endmodule
`default_nettype wire

@@ sv/pubsub_constraint_match_counter_core.sv @@
`default_nettype none
// channel  | dir | contents
// s_axis   | in  | tdata: cmd, sub_index, slot_index, constraint_count, attribute,
//          |     |        op_code, low_bound, high_bound, event_value; tuser: last_pair
// m_axis   | out | tdata: match_count
// cfg      | in  | active_subscriptions
// table loads and event pairs are accepted back to back while idle
// a last pair walks one constraint slot per cycle, the rate set by the single
// constraint memory read port
// after reset a clearing pass zeroes the size memory while input is held off
// input stalls while a walk runs or the count waits on m_axis
module pubsub_constraint_match_counter_core #(
  parameter int unsigned MAX_SUBS        = pscm_pkg::MaxSubs,
  parameter int unsigned MAX_CONSTRAINTS = pscm_pkg::MaxConstraints,
  parameter int unsigned MAX_PAIRS       = pscm_pkg::MaxPairs
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output      logic         s_axis_tready,
  // cmd[1:0] sub_index[11:2] slot_index[14:12] constraint_count[18:15]
  // attribute[24:19] op_code[26:25] low_bound[58:27] high_bound[90:59] event_value[122:91]
  input  wire logic [127:0] s_axis_tdata,
  input  wire logic         s_axis_tuser,    // last_pair
  output      logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output      logic [15:0]  m_axis_tdata,    // match_count[10:0]
  input  wire logic         cfg_we_i,
  input  wire logic [10:0]  cfg_wdata_i
);
  localparam int unsigned VB = pscm_pkg::ValueBits;
  localparam int unsigned SW = (MAX_SUBS > 1) ? $clog2(MAX_SUBS) : 1;
  localparam int unsigned CW = (MAX_CONSTRAINTS > 1) ? $clog2(MAX_CONSTRAINTS) : 1;
  localparam int unsigned PW = $clog2(MAX_PAIRS + 1);
  localparam int unsigned NW = $clog2(MAX_CONSTRAINTS + 1);
  localparam int unsigned AW = $clog2(MAX_SUBS + 1);
  localparam int unsigned DEPTH = MAX_SUBS * MAX_CONSTRAINTS;
  localparam int unsigned TW = $clog2(DEPTH);
  localparam int unsigned EW = 6 + 2 + 2 * VB;

  // field unpacking
  logic [1:0]    f_cmd;
  logic [9:0]    f_sub;
  logic [2:0]    f_slot;
  logic [3:0]    f_cnt;
  logic [5:0]    f_attr;
  logic [1:0]    f_op;
  logic [VB-1:0] f_lo, f_hi, f_val;
  assign f_cmd  = s_axis_tdata[1:0];
  assign f_sub  = s_axis_tdata[11:2];
  assign f_slot = s_axis_tdata[14:12];
  assign f_cnt  = s_axis_tdata[18:15];
  assign f_attr = s_axis_tdata[24:19];
  assign f_op   = s_axis_tdata[26:25];
  assign f_lo   = s_axis_tdata[58:27];
  assign f_hi   = s_axis_tdata[90:59];
  assign f_val  = s_axis_tdata[122:91];

  pscm_pkg::state_e state_q, state_d;
  logic acc;
  assign acc = s_axis_tvalid && s_axis_tready;

  logic sub_ok, slot_ok;
  assign sub_ok  = 32'(f_sub) < MAX_SUBS;
  assign slot_ok = 32'(f_slot) < MAX_CONSTRAINTS;

  // config register, saturated
  logic [AW-1:0] active_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (cfg_we_i) begin
      active_q <= (32'(cfg_wdata_i) > MAX_SUBS) ? AW'(MAX_SUBS) : AW'(cfg_wdata_i);
    end
  end

  // constraint memory, one synchronous read port
  logic [EW-1:0] cmem [DEPTH];
  logic [EW-1:0] crd_q;
  logic [TW-1:0] c_waddr, c_raddr;
  logic          c_we;
  assign c_we    = acc && (f_cmd == pscm_pkg::CMD_WRITE_CONSTRAINT) && sub_ok && slot_ok;
  assign c_waddr = TW'(32'(f_sub) * MAX_CONSTRAINTS + 32'(f_slot));
  always_ff @(posedge clk_i) begin
    if (c_we) cmem[c_waddr] <= {f_hi, f_lo, f_op, f_attr};
    crd_q <= cmem[c_raddr];
  end

  // subscription size memory, zeroed by a clearing pass after reset
  logic [NW-1:0] smem [MAX_SUBS];
  logic [NW-1:0] srd_q;
  logic [NW-1:0] s_wdata;
  logic          s_we;
  logic          clearing, clr_done;
  logic [SW-1:0] clr_q;
  logic [SW-1:0] s_waddr, s_raddr;
  assign clearing = (state_q == pscm_pkg::ST_CLEAR);
  assign clr_done = clearing && (32'(clr_q) == MAX_SUBS - 1);
  assign s_we     = clearing || (acc && (f_cmd == pscm_pkg::CMD_SET_COUNT) && sub_ok);
  assign s_waddr  = clearing ? clr_q : SW'(f_sub);
  assign s_wdata  = clearing ? '0 :
                    ((32'(f_cnt) > MAX_CONSTRAINTS) ? NW'(MAX_CONSTRAINTS) : NW'(f_cnt));
  always_ff @(posedge clk_i) begin
    if (s_we) smem[s_waddr] <= s_wdata;
    srd_q <= smem[s_raddr];
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (clearing) begin
      clr_q <= clr_q + SW'(1);
    end
  end

  // event pair buffer
  logic [MAX_PAIRS-1:0][5:0]  pattr_q;
  logic [MAX_PAIRS-1:0][VB-1:0] pval_q;
  logic [PW-1:0]              fill_q;
  logic [MAX_PAIRS-1:0]       pvalid;
  logic                       is_pair;
  assign is_pair = acc && (f_cmd == pscm_pkg::CMD_EVENT_PAIR);
  always_ff @(posedge clk_i) begin
    for (int p = 0; p < MAX_PAIRS; p++) begin
      if (is_pair && 32'(fill_q) == p) begin
        pattr_q[p] <= f_attr;
        pval_q[p]  <= f_val;
      end
    end
  end
  always_comb begin
    for (int p = 0; p < MAX_PAIRS; p++) pvalid[p] = p < 32'(fill_q);
  end

  // walk counters: stage 0 issues reads, stage 1 evaluates
  logic [AW-1:0] sub_q;
  logic [CW-1:0] slot_q;
  logic          s1_v_q, s1_first_q, s1_lastslot_q;
  logic          fail_q;
  logic [AW-1:0] cnt_q;
  logic          issue, last_slot;
  assign issue     = (state_q == pscm_pkg::ST_WALK);
  assign last_slot = 32'(slot_q) == MAX_CONSTRAINTS - 1;
  assign c_raddr   = TW'(32'(sub_q) * MAX_CONSTRAINTS + 32'(slot_q));
  assign s_raddr   = SW'(sub_q);

  logic hit;
  pscm_eval #(.MAX_PAIRS(MAX_PAIRS), .VALUE_BITS(VB)) u_eval (
    .pair_valid_i(pvalid),
    .pair_attr_i (pattr_q),
    .pair_val_i  (pval_q),
    .c_attr_i    (crd_q[5:0]),
    .c_op_i      (crd_q[7:6]),
    .c_lo_i      (crd_q[8 +: VB]),
    .c_hi_i      (crd_q[8+VB +: VB]),
    .hit_o       (hit)
  );

  logic [AW-1:0] slot_idx1_q;
  logic [NW-1:0] size1;
  logic          fail_now;
  assign size1    = srd_q;
  assign fail_now = (32'(slot_idx1_q) < 32'(size1)) && !hit;

  // next state
  logic walk_done;
  assign walk_done = issue && last_slot && (32'(sub_q) + 1 >= 32'(active_q));
  always_comb begin
    state_d = state_q;
    case (state_q)
      pscm_pkg::ST_CLEAR: if (clr_done) state_d = pscm_pkg::ST_IDLE;
      pscm_pkg::ST_IDLE:  if (is_pair && s_axis_tuser)
                            state_d = (active_q == '0) ? pscm_pkg::ST_OUT : pscm_pkg::ST_WALK;
      pscm_pkg::ST_WALK:  if (walk_done) state_d = pscm_pkg::ST_DRAIN;
      pscm_pkg::ST_DRAIN: state_d = pscm_pkg::ST_OUT;
      pscm_pkg::ST_OUT:   if (m_axis_tready) state_d = pscm_pkg::ST_IDLE;
      default:            state_d = pscm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= pscm_pkg::ST_CLEAR;
      fill_q        <= '0;
      sub_q         <= '0;
      slot_q        <= '0;
      s1_v_q        <= 1'b0;
      s1_first_q    <= 1'b0;
      s1_lastslot_q <= 1'b0;
      slot_idx1_q   <= '0;
      fail_q        <= 1'b0;
      cnt_q         <= '0;
    end else begin
      state_q <= state_d;
      // pair fill, emptied once the count is taken
      if (state_q == pscm_pkg::ST_OUT && m_axis_tready) fill_q <= '0;
      else if (is_pair && 32'(fill_q) < MAX_PAIRS) fill_q <= fill_q + PW'(1);
      // start of walk
      if (is_pair && s_axis_tuser) begin
        sub_q  <= '0;
        slot_q <= '0;
        cnt_q  <= '0;
      end
      // issue stage
      s1_v_q        <= issue;
      s1_first_q    <= issue && (slot_q == '0);
      s1_lastslot_q <= last_slot;
      slot_idx1_q   <= AW'(slot_q);
      if (issue) begin
        if (last_slot) begin
          slot_q <= '0;
          sub_q  <= sub_q + AW'(1);
        end else begin
          slot_q <= slot_q + CW'(1);
        end
      end
      // evaluate stage
      if (s1_v_q) begin
        if (s1_lastslot_q) begin
          if (!((s1_first_q ? 1'b0 : fail_q) || fail_now)) cnt_q <= cnt_q + AW'(1);
          fail_q <= 1'b0;
        end else begin
          fail_q <= (s1_first_q ? 1'b0 : fail_q) || fail_now;
        end
      end
    end
  end

  // output
  always_comb begin
    s_axis_tready = (state_q == pscm_pkg::ST_IDLE);
    m_axis_tvalid = (state_q == pscm_pkg::ST_OUT);
    m_axis_tdata  = 16'(cnt_q);
  end
endmodule
`default_nettype wire

@@ dv/pubsub_constraint_match_counter_checker.sv @@
`default_nettype none
module pubsub_constraint_match_counter_checker (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  input  wire logic         s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,
  input  wire logic         s_axis_tuser,
  input  wire logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  input  wire logic [15:0]  m_axis_tdata,
  input  wire logic         cfg_we_i,
  input  wire logic [10:0]  cfg_wdata_i,
  output int                fail_count_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // mirror of the subscription table and the pair buffer
  logic [5:0]       rule_attr [pscm_pkg::MaxSubs*pscm_pkg::MaxConstraints];
  pscm_pkg::op_e    rule_op   [pscm_pkg::MaxSubs*pscm_pkg::MaxConstraints];
  logic [31:0]      rule_lo   [pscm_pkg::MaxSubs*pscm_pkg::MaxConstraints];
  logic [31:0]      rule_hi   [pscm_pkg::MaxSubs*pscm_pkg::MaxConstraints];
  logic [3:0]       sub_size  [pscm_pkg::MaxSubs];
  logic [5:0]       pair_attr [pscm_pkg::MaxPairs];
  logic [31:0]      pair_val  [pscm_pkg::MaxPairs];
  int unsigned      pair_fill;
  logic [10:0]      active_subs;
  logic [10:0]      want_fifo [16];
  int unsigned      wr_ptr, rd_ptr;
  int               fails;

  assign fail_count_o = fails;
  assign pending_o    = int'(wr_ptr - rd_ptr);

  // does buffered pair p satisfy constraint c
  function automatic bit pair_hits(int unsigned c, int unsigned p);
    logic [31:0] v;
    v = pair_val[p];
    if (pair_attr[p] != rule_attr[c]) return 1'b0;
    case (rule_op[c])
      pscm_pkg::OP_EQ: return v == rule_lo[c];
      pscm_pkg::OP_GE: return v >= rule_lo[c];
      pscm_pkg::OP_LE: return v <= rule_lo[c];
      default:         return v >= rule_lo[c] && v <= rule_hi[c];
    endcase
  endfunction

  // count active subscriptions whose every constraint is met
  function automatic logic [10:0] count_matches();
    int unsigned n, total;
    bit sub_ok, hit;
    n = (active_subs > pscm_pkg::MaxSubs) ? pscm_pkg::MaxSubs : active_subs;
    total = 0;
    for (int unsigned s = 0; s < n; s++) begin
      sub_ok = 1'b1;
      for (int unsigned j = 0; j < sub_size[s]; j++) begin
        hit = 1'b0;
        for (int unsigned p = 0; p < pair_fill; p++) begin
          if (pair_hits(s * pscm_pkg::MaxConstraints + j, p)) hit = 1'b1;
        end
        if (!hit) sub_ok = 1'b0;
      end
      if (sub_ok) total++;
    end
    return total[10:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pscm_pkg::cmd_e cmd;
    logic [9:0]     sub;
    logic [2:0]     slot;
    logic [3:0]     cnt;
    logic [10:0]    want;
    int unsigned    c;
    if (!rst_ni) begin
      foreach (sub_size[i]) sub_size[i] = '0;
      pair_fill   = 0;
      active_subs = '0;
      wr_ptr      = 0;
      rd_ptr      = 0;
      fails       = 0;
    end else begin
      // compare each accepted count with the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        if (wr_ptr == rd_ptr) begin
          fails++;
          if (fails <= 10) $display("%0t: unexpected count %0d", $realtime, m_axis_tdata[10:0]);
        end else begin
          want = want_fifo[rd_ptr % 16];
          rd_ptr++;
          if (m_axis_tdata[10:0] !== want) begin
            fails++;
            if (fails <= 10)
              $display("%0t: match_count expected %0d got %0d", $realtime, want,
                       m_axis_tdata[10:0]);
          end
        end
      end
      if (cfg_we_i) active_subs = cfg_wdata_i;
      // apply each accepted item to the mirror
      if (s_axis_tvalid && s_axis_tready) begin
        cmd  = pscm_pkg::cmd_e'(s_axis_tdata[1:0]);
        sub  = s_axis_tdata[11:2];
        slot = s_axis_tdata[14:12];
        cnt  = s_axis_tdata[18:15];
        case (cmd)
          pscm_pkg::CMD_WRITE_CONSTRAINT: begin
            c = sub * pscm_pkg::MaxConstraints + slot;
            rule_attr[c] = s_axis_tdata[24:19];
            rule_op[c]   = pscm_pkg::op_e'(s_axis_tdata[26:25]);
            rule_lo[c]   = s_axis_tdata[58:27];
            rule_hi[c]   = s_axis_tdata[90:59];
          end
          pscm_pkg::CMD_SET_COUNT:
            sub_size[sub] = (cnt > pscm_pkg::MaxConstraints) ? pscm_pkg::MaxConstraints : cnt;
          pscm_pkg::CMD_EVENT_PAIR: begin
            if (pair_fill < pscm_pkg::MaxPairs) begin
              pair_attr[pair_fill] = s_axis_tdata[24:19];
              pair_val[pair_fill]  = s_axis_tdata[122:91];
              pair_fill++;
            end
            if (s_axis_tuser) begin
              want_fifo[wr_ptr % 16] = count_matches();
              wr_ptr++;
              pair_fill = 0;
            end
          end
          default: ;
        endcase
      end
    end
  end
endmodule
`default_nettype wire

@@ dv/pubsub_constraint_match_counter_core_test.sv @@
`default_nettype none
module pubsub_constraint_match_counter_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;   // cmd, sub, slot, count, attr, op, lo, hi, value
  logic         s_axis_tuser;   // last_pair
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [15:0]  m_axis_tdata;   // match_count
  logic         cfg_we_i;
  logic [10:0]  cfg_wdata_i;
  int           fail_count;
  int           pending;

  int           items_sent;
  int           send_streak;
  int           recv_streak;
  logic [7:0]   written_slots [pscm_pkg::MaxSubs];
  logic [10:0]  active_now;

  pubsub_constraint_match_counter_core dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_wdata_i
  );

  pubsub_constraint_match_counter_checker checker_i (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_wdata_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always #5 clk_i = ~clk_i;

  // gap draw with occasional runs of back-to-back cycles
  function automatic int draw_gap(ref int streak);
    if (streak > 0) begin
      streak--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) streak = $urandom_range(10, 30);
    return $urandom_range(0, 8);
  endfunction

  // drive one item and hold it until accepted
  task automatic send_item(pscm_pkg::cmd_e cmd, logic [9:0] sub, logic [2:0] slot,
                           logic [3:0] cnt, logic [5:0] attr, pscm_pkg::op_e op,
                           logic [31:0] lo, logic [31:0] hi, logic [31:0] val, logic last);
    int gap;
    gap = draw_gap(send_streak);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, val, hi, lo, op, attr, cnt, slot, sub, cmd};
    s_axis_tuser  <= last;
    forever begin
      @(negedge clk_i);
      if (s_axis_tready) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
    items_sent++;
  endtask

  task automatic write_rule(logic [9:0] sub, logic [2:0] slot, logic [5:0] attr,
                            pscm_pkg::op_e op, logic [31:0] lo, logic [31:0] hi);
    send_item(pscm_pkg::CMD_WRITE_CONSTRAINT, sub, slot, 4'($urandom), attr, op, lo, hi,
              $urandom, 1'($urandom));
    written_slots[sub][slot] = 1'b1;
  endtask

  task automatic set_size(logic [9:0] sub, logic [3:0] cnt);
    send_item(pscm_pkg::CMD_SET_COUNT, sub, 3'($urandom), cnt, 6'($urandom),
              pscm_pkg::op_e'($urandom), $urandom, $urandom, $urandom, 1'($urandom));
  endtask

  task automatic send_pair(logic [5:0] attr, logic [31:0] val, logic last);
    send_item(pscm_pkg::CMD_EVENT_PAIR, 10'($urandom), 3'($urandom), 4'($urandom), attr,
              pscm_pkg::op_e'($urandom), $urandom, $urandom, val, last);
  endtask

  // wait until every count is out, then let the block settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_active(logic [10:0] n);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= n;
    active_now  = n;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  // values cluster near a few points so constraints hit and miss
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return 32'hffff_ffff;
      default: return $urandom_range(0, 15);
    endcase
  endfunction

  function automatic logic [5:0] pick_attr();
    return ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 3));
  endfunction

  function automatic logic [9:0] pick_sub();
    return ($urandom_range(0, 19) == 0) ? 10'($urandom) : 10'($urandom_range(0, 47));
  endfunction

  // random count clipped so no unwritten slot is ever counted
  task automatic random_size(logic [9:0] sub);
    logic [3:0] cnt;
    int unsigned eff, k;
    cnt = 4'($urandom);
    eff = (cnt > pscm_pkg::MaxConstraints) ? pscm_pkg::MaxConstraints : cnt;
    k = 0;
    while (k < pscm_pkg::MaxConstraints && written_slots[sub][k]) k++;
    if (eff > k) cnt = 4'(k);
    set_size(sub, cnt);
  endtask

  task automatic random_event();
    int len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 4);
    for (int i = 1; i <= len; i++) send_pair(pick_attr(), pick_value(), i == len);
  endtask

  // receiver with random stalls
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    recv_streak   = 0;
    @(posedge rst_ni);
    forever begin
      gap = draw_gap(recv_streak);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      forever begin
        @(negedge clk_i);
        if (m_axis_tvalid) break;
        @(posedge clk_i);
      end
      @(posedge clk_i);
    end
  end

  // stimulus
  initial begin
    int phase, budget, start, r;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    items_sent    = 0;
    send_streak   = 0;
    foreach (written_slots[i]) written_slots[i] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty subscriptions, every operator, saturation, empty interval
    set_active(11'd4);
    send_pair(6'd63, 32'hffff_ffff, 1'b1);
    write_rule(10'd0, 3'd0, 6'd0, pscm_pkg::OP_EQ, 32'd0, 32'd0);
    write_rule(10'd0, 3'd1, 6'd63, pscm_pkg::OP_GE, 32'hffff_ffff, 32'd0);
    write_rule(10'd0, 3'd2, 6'd1, pscm_pkg::OP_LE, 32'd0, 32'hffff_ffff);
    write_rule(10'd0, 3'd3, 6'd2, pscm_pkg::OP_RNG, 32'd5, 32'd9);
    write_rule(10'd0, 3'd4, 6'd3, pscm_pkg::OP_RNG, 32'd9, 32'd5);
    write_rule(10'd0, 3'd5, 6'd0, pscm_pkg::OP_GE, 32'd0, 32'd0);
    write_rule(10'd0, 3'd6, 6'd1, pscm_pkg::OP_LE, 32'hffff_ffff, 32'd0);
    write_rule(10'd0, 3'd7, 6'd2, pscm_pkg::OP_EQ, 32'd7, 32'd0);
    set_size(10'd0, 4'd15);
    write_rule(10'd1, 3'd0, 6'd2, pscm_pkg::OP_RNG, 32'd0, 32'hffff_ffff);
    set_size(10'd1, 4'd1);
    write_rule(10'd1023, 3'd7, 6'd63, pscm_pkg::OP_RNG, 32'hffff_ffff, 32'hffff_ffff);
    set_size(10'd1023, 4'd0);
    send_item(pscm_pkg::CMD_UNUSED, 10'h3ff, 3'd7, 4'hf, 6'h3f, pscm_pkg::OP_RNG,
              32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
    send_pair(6'd0, 32'd0, 1'b0);
    send_pair(6'd1, 32'd0, 1'b0);
    send_pair(6'd2, 32'd7, 1'b0);
    send_pair(6'd63, 32'hffff_ffff, 1'b1);
    set_active(11'd0);
    send_pair(6'd2, 32'd7, 1'b1);

    // random phases, each under its own table size
    phase = 0;
    while (items_sent < 580) begin
      phase++;
      if (phase == 3) set_active(11'd1024);
      else if (phase == 6) set_active(11'd2047);
      else set_active(11'($urandom_range(1, 48)));
      budget = (active_now > 64) ? 12 : 60;
      start  = items_sent;
      while (items_sent - start < budget) begin
        r = $urandom_range(0, 99);
        if (r < 35) begin
          write_rule(pick_sub(), 3'($urandom), pick_attr(), pscm_pkg::op_e'($urandom),
                     pick_value(), pick_value());
        end else if (r < 50) begin
          random_size(pick_sub());
        end else if (r < 55) begin
          send_item(pscm_pkg::CMD_UNUSED, 10'($urandom), 3'($urandom), 4'($urandom),
                    6'($urandom), pscm_pkg::op_e'($urandom), $urandom, $urandom, $urandom,
                    1'($urandom));
        end else if (active_now <= 64 || items_sent - start > budget - 6) begin
          random_event();
        end
      end
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire

@@ pubsub_constraint_match_counter_core.f @@
sv/pscm_pkg.sv
sv/pscm_eval.sv
sv/pubsub_constraint_match_counter_core.sv
dv/pubsub_constraint_match_counter_checker.sv
dv/pubsub_constraint_match_counter_core_test.sv
